[sv/gtge_pkg.sv]
package gtge_pkg;

  localparam int COLS_W      = 9;
  localparam int CODE_W      = 8;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int NODE_OUT_W  = 16;

  localparam int MAX_COLS_DEF  = 256;
  localparam int NODE_BITS_DEF = 16;

  localparam logic [COLS_W-1:0] COLS_RST  = 9'd256;
  localparam logic              MODE_RST  = 1'b0;
  localparam logic [CODE_W-1:0] OBST_RST  = 8'd1;
  localparam logic [CODE_W-1:0] WALL_RST  = 8'd2;
  localparam logic [CODE_W-1:0] PATH_RST  = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS  = 3'd0,
    CFG_MODE     = 3'd1,
    CFG_OBSTACLE = 3'd2,
    CFG_WALL     = 3'd3,
    CFG_PATH     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CODE_W-1:0] cell_code;
    logic              start_of_map;
  } gtge_in_t;

  typedef struct packed {
    logic [NODE_OUT_W-1:0] from_node;
    logic [NODE_OUT_W-1:0] to_node;
    logic                  edge_dir;
    logic                  last_edge;
  } gtge_out_t;

  // Edges still owed by the cell held in the stage register.
  typedef struct packed {
    logic horiz;
    logic vert;
  } gtge_pend_t;

  // Edges moved into the result register in this cycle.
  typedef struct packed {
    logic horiz;
    logic vert;
  } gtge_take_t;

endpackage

[sv/gtge_scan.sv]
module gtge_scan #(
  parameter int MAX_COLS  = gtge_pkg::MAX_COLS_DEF,
  parameter int NODE_BITS = gtge_pkg::NODE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gtge_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gtge_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gtge_pkg::gtge_in_t               in_data,
  input  gtge_pkg::gtge_take_t             take,
  output gtge_pkg::gtge_pend_t             pend,
  output logic [NODE_BITS-1:0]             idx,
  output logic [NODE_BITS-1:0]             above_idx
);

  localparam int CB    = $clog2(MAX_COLS);
  localparam int CNT_W = CB + 1;
  localparam int CW    = (CNT_W > gtge_pkg::COLS_W) ? CNT_W : gtge_pkg::COLS_W;

  logic [gtge_pkg::COLS_W-1:0] cols_r;
  logic                        mode_r;
  logic [gtge_pkg::CODE_W-1:0] obst_r;
  logic [gtge_pkg::CODE_W-1:0] wall_r;
  logic [gtge_pkg::CODE_W-1:0] path_r;

  logic [NODE_BITS:0]   next_r, next_nxt;
  logic [CB-1:0]        col_r, col_nxt;
  logic                 first_r, first_nxt;
  logic                 left_r, left_nxt;
  logic                 h_r, chk_r;
  logic [NODE_BITS-1:0] idx_r;
  logic [NODE_BITS:0]   ab_r;
  logic [NODE_BITS:0]   mem [MAX_COLS];

  logic                 accept;
  logic [CW-1:0]        cols_ext, cols_eff;
  logic [NODE_BITS:0]   n_cur;
  logic [CB-1:0]        c_cur;
  logic [CNT_W-1:0]     c_inc;
  logic                 f_cur, l_cur;
  logic                 free_cell, is_node, hz, ck;
  logic [NODE_BITS:0]   wr_entry;

  assign accept = in_valid & ~in_stall;

  assign cols_ext = CW'(cols_r);
  always_comb begin
    if (cols_ext == '0) begin
      cols_eff = CW'(1);
    end else if (cols_ext > CW'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
  end

  always_comb begin
    n_cur = in_data.start_of_map ? '0 : next_r;
    c_cur = in_data.start_of_map ? '0 : col_r;
    f_cur = in_data.start_of_map ? 1'b1 : first_r;
    l_cur = in_data.start_of_map ? 1'b0 : left_r;
    if (CW'(c_cur) >= cols_eff) begin
      c_cur = '0;
      f_cur = 1'b0;
      l_cur = 1'b0;
    end
    if (mode_r) begin
      free_cell = (in_data.cell_code == path_r);
    end else begin
      free_cell = (in_data.cell_code != obst_r) && (in_data.cell_code != wall_r);
    end
    is_node  = free_cell & ~n_cur[NODE_BITS];
    hz       = is_node & l_cur & (c_cur != '0);
    ck       = is_node & ~f_cur;
    wr_entry = is_node ? {1'b1, n_cur[NODE_BITS-1:0]} : '0;
    next_nxt = is_node ? n_cur + (NODE_BITS+1)'(1) : n_cur;
    c_inc    = {1'b0, c_cur} + CNT_W'(1);
    if (CW'(c_inc) >= cols_eff) begin
      col_nxt   = '0;
      first_nxt = 1'b0;
      left_nxt  = 1'b0;
    end else begin
      col_nxt   = c_inc[CB-1:0];
      first_nxt = f_cur;
      left_nxt  = is_node;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= gtge_pkg::COLS_RST;
      mode_r  <= gtge_pkg::MODE_RST;
      obst_r  <= gtge_pkg::OBST_RST;
      wall_r  <= gtge_pkg::WALL_RST;
      path_r  <= gtge_pkg::PATH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gtge_pkg::CFG_COLUMNS:  cols_r <= cfg_data;
        gtge_pkg::CFG_MODE:     mode_r <= cfg_data[0];
        gtge_pkg::CFG_OBSTACLE: obst_r <= cfg_data[gtge_pkg::CODE_W-1:0];
        gtge_pkg::CFG_WALL:     wall_r <= cfg_data[gtge_pkg::CODE_W-1:0];
        gtge_pkg::CFG_PATH:     path_r <= cfg_data[gtge_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r  <= '0;
      col_r   <= '0;
      first_r <= 1'b1;
      left_r  <= 1'b0;
      h_r     <= 1'b0;
      chk_r   <= 1'b0;
    end else if (accept) begin
      next_r  <= next_nxt;
      col_r   <= col_nxt;
      first_r <= first_nxt;
      left_r  <= left_nxt;
      h_r     <= hz;
      chk_r   <= ck;
    end else begin
      if (take.horiz) begin
        h_r <= 1'b0;
      end
      if (take.vert) begin
        chk_r <= 1'b0;
      end
    end
  end

  // The read sees the entry of the previous row; the write replaces it.
  always_ff @(posedge clk) begin
    if (accept) begin
      ab_r       <= mem[c_cur];
      mem[c_cur] <= wr_entry;
      idx_r      <= n_cur[NODE_BITS-1:0];
    end
  end

  assign pend.horiz = h_r;
  assign pend.vert  = chk_r & ab_r[NODE_BITS];
  assign in_stall   = (h_r & ~take.horiz) | (pend.vert & ~take.vert);
  assign idx        = idx_r;
  assign above_idx  = ab_r[NODE_BITS-1:0];

  a_node_limit: assert property (@(posedge clk) disable iff (!rst_n)
    next_r <= (NODE_BITS+1)'(1) << NODE_BITS)
    else $error("node counter ran past its limit");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.start_of_map |=> next_r <= (NODE_BITS+1)'(1))
    else $error("start of map did not restart numbering");

  a_left_edge: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !(h_r && idx_r == '0))
    else $error("horizontal edge owed by the first node");

endmodule

[sv/gtge_emit.sv]
module gtge_emit #(
  parameter int NODE_BITS = gtge_pkg::NODE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gtge_pkg::gtge_pend_t  pend,
  input  logic [NODE_BITS-1:0]  idx,
  input  logic [NODE_BITS-1:0]  above_idx,
  output gtge_pkg::gtge_take_t  take,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gtge_pkg::gtge_out_t   out_data
);

  localparam int WW = (NODE_BITS > gtge_pkg::NODE_OUT_W) ? NODE_BITS : gtge_pkg::NODE_OUT_W;

  logic                out_valid_r, out_valid_nxt;
  gtge_pkg::gtge_out_t out_data_r, out_data_nxt;
  logic                load;
  logic [WW-1:0]       to_w, left_w, above_w;

  assign load       = (pend.horiz | pend.vert) & (~out_valid_r | ~out_stall);
  assign take.horiz = load & pend.horiz;
  assign take.vert  = load & ~pend.horiz & pend.vert;

  assign to_w    = WW'(idx);
  assign left_w  = WW'(idx - NODE_BITS'(1));
  assign above_w = WW'(above_idx);

  always_comb begin
    out_data_nxt.to_node = to_w[gtge_pkg::NODE_OUT_W-1:0];
    if (pend.horiz) begin
      out_data_nxt.from_node = left_w[gtge_pkg::NODE_OUT_W-1:0];
      out_data_nxt.edge_dir  = 1'b0;
      out_data_nxt.last_edge = ~pend.vert;
    end else begin
      out_data_nxt.from_node = above_w[gtge_pkg::NODE_OUT_W-1:0];
      out_data_nxt.edge_dir  = 1'b1;
      out_data_nxt.last_edge = 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last_edge |-> out_data_r.edge_dir == 1'b0)
    else $error("vertical edge issued ahead of a horizontal one");

endmodule

[sv/grid_to_graph_edges.sv]
// Turns a map streamed one cell per item in row-major order into the edges of its grid graph.
// Each free cell gets the next node index; a free cell emits an edge to a free left neighbor
// first and then one to a free cell above, the last of them flagged with last_edge. A cell
// that yields both a horizontal and a vertical edge stalls the input until the vertical one
// is taken, as both leave through the single result register. The line store of the previous
// row is read and rewritten in the cycle a cell is accepted, so no clearing pass follows
// reset; the first row of every map must begin with start_of_map set.
module grid_to_graph_edges #(
  parameter int MAX_COLS  = gtge_pkg::MAX_COLS_DEF,
  parameter int NODE_BITS = gtge_pkg::NODE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gtge_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gtge_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gtge_pkg::gtge_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gtge_pkg::gtge_out_t            out_data
);

  gtge_pkg::gtge_pend_t pend;
  gtge_pkg::gtge_take_t take;
  logic [NODE_BITS-1:0] idx;
  logic [NODE_BITS-1:0] above_idx;

  gtge_scan #(
    .MAX_COLS  (MAX_COLS),
    .NODE_BITS (NODE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .take      (take),
    .pend      (pend),
    .idx       (idx),
    .above_idx (above_idx)
  );

  gtge_emit #(
    .NODE_BITS (NODE_BITS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .pend      (pend),
    .idx       (idx),
    .above_idx (above_idx),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
